>>> src/rigid_pose_chain_converter_unit_defines.svh
// Assertion macros used by the pose chain converter top level.
`ifndef RIGID_POSE_CHAIN_CONVERTER_UNIT_DEFINES_SVH
`define RIGID_POSE_CHAIN_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPCC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpcc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RPCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpcc: next-cycle check failed");

`endif

>>> src/rpcc_pkg.sv
// Shared types, constants and microcode program of the pose chain converter.
`default_nettype none

package rpcc_pkg;

    localparam int POSE_WORDS = 12;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 4;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 30;

    localparam int LOCAL_BASE = 1;
    localparam int WORLD_BASE = 50;
    localparam int DRAIN_NOPS = 3;
    localparam int UC_DEPTH   = 93;
    localparam int PC_W       = 7;

    localparam logic [WORD_W-1:0] Q30_ONE = 32'h4000_0000;

    typedef logic [POSE_WORDS-1:0][WORD_W-1:0] pose_t;

    typedef enum logic [1:0] {
        SRC_CUR,
        SRC_PREV,
        SRC_RES,
        SRC_ONE
    } operand_src_t;

    typedef struct packed {
        logic             jump_world;
        logic [PC_W-1:0]  target;
        logic             mac;
        operand_src_t     a_src;
        logic [IDX_W-1:0] a_idx;
        operand_src_t     b_src;
        logic [IDX_W-1:0] b_idx;
        logic             sub;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] dst;
        logic             done;
    } ucode_word_t;

    typedef ucode_word_t [UC_DEPTH-1:0] ucode_rom_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic        capture;
        logic        issue;
        ucode_word_t word;
        logic        commit;
        logic        mode;
    } dp_ctrl_t;

    function automatic ucode_word_t mac_word(operand_src_t as, int ai, operand_src_t bs,
                                             int bi, logic sub, logic first, logic last,
                                             int dst);
        ucode_word_t w;
        w       = '0;
        w.mac   = 1'b1;
        w.a_src = as;
        w.a_idx = IDX_W'(ai);
        w.b_src = bs;
        w.b_idx = IDX_W'(bi);
        w.sub   = sub;
        w.first = first;
        w.last  = last;
        w.dst   = IDX_W'(dst);
        return w;
    endfunction

    function automatic ucode_rom_t build_rom();
        ucode_rom_t rom;
        int pc;
        rom = '0;
        // dispatch: world mode jumps over the local program
        rom[PC_W'(0)].jump_world = 1'b1;
        rom[PC_W'(0)].target     = PC_W'(WORLD_BASE);

        // local: out_R = C_R^T P_R, out_t = C_R^T P_t - C_R^T C_t
        pc = LOCAL_BASE;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    rom[PC_W'(pc)] = mac_word(SRC_CUR, k * 4 + r, SRC_PREV, k * 4 + c, 1'b0,
                                              k == 0, k == 2, r * 4 + c);
                    pc++;
                end
            end
            for (int k = 0; k < 3; k++) begin
                rom[PC_W'(pc)] = mac_word(SRC_CUR, k * 4 + r, SRC_PREV, k * 4 + 3, 1'b0,
                                          k == 0, 1'b0, r * 4 + 3);
                pc++;
            end
            for (int k = 0; k < 3; k++) begin
                rom[PC_W'(pc)] = mac_word(SRC_CUR, k * 4 + r, SRC_CUR, k * 4 + 3, 1'b1,
                                          1'b0, k == 2, r * 4 + 3);
                pc++;
            end
        end
        pc += DRAIN_NOPS;
        rom[PC_W'(pc)].done = 1'b1;

        // world: out_R = P_R C_R^T, out_t = P_t - out_R C_t
        pc = WORLD_BASE;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    rom[PC_W'(pc)] = mac_word(SRC_PREV, r * 4 + k, SRC_CUR, c * 4 + k, 1'b0,
                                              k == 0, k == 2, r * 4 + c);
                    pc++;
                end
            end
        end
        for (int r = 0; r < 3; r++) begin
            rom[PC_W'(pc)] = mac_word(SRC_PREV, r * 4 + 3, SRC_ONE, 0, 1'b0, 1'b1, 1'b0,
                                      r * 4 + 3);
            pc++;
            for (int k = 0; k < 3; k++) begin
                rom[PC_W'(pc)] = mac_word(SRC_RES, r * 4 + k, SRC_CUR, k * 4 + 3, 1'b1,
                                          1'b0, k == 2, r * 4 + 3);
                pc++;
            end
        end
        pc += DRAIN_NOPS;
        rom[PC_W'(pc)].done = 1'b1;
        return rom;
    endfunction

    function automatic pose_t identity_pose();
        pose_t p;
        p = '0;
        for (int r = 0; r < 3; r++) begin
            p[IDX_W'(r * 4 + r)] = Q30_ONE;
        end
        return p;
    endfunction

    localparam ucode_rom_t UCODE_ROM     = build_rom();
    localparam pose_t      POSE_IDENTITY = identity_pose();

endpackage

`default_nettype wire

>>> src/rigid_pose_chain_converter_unit.sv
// Top level of the rigid pose chain converter: ports, sequencer and datapath.
//
//   channel  direction  handshake          beat
//   s_*      in         s_valid/s_ready    one 3x4 pose
//   m_*      out        m_valid/m_ready    one converted 3x4 pose
//   cfg_*    in         cfg_we             direction mode bit
//
// Each pose runs from accept to the next accept through the single shared 32x32
// multiplier, one product per cycle: 45 products in local mode or 39 in world mode,
// plus the accept, dispatch, a pipeline drain, the done step and the commit.
// Reset is synchronous and sets the stored pose to identity; no clearing pass.
// A result that waits on m_ready holds the commit, but the next pose is taken as
// soon as the previous one has moved into the output register.
`default_nettype none
`include "rigid_pose_chain_converter_unit_defines.svh"

module rigid_pose_chain_converter_unit
    import rpcc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_rot_00,
    input  wire logic signed [31:0] s_rot_01,
    input  wire logic signed [31:0] s_rot_02,
    input  wire logic signed [31:0] s_trans_x,
    input  wire logic signed [31:0] s_rot_10,
    input  wire logic signed [31:0] s_rot_11,
    input  wire logic signed [31:0] s_rot_12,
    input  wire logic signed [31:0] s_trans_y,
    input  wire logic signed [31:0] s_rot_20,
    input  wire logic signed [31:0] s_rot_21,
    input  wire logic signed [31:0] s_rot_22,
    input  wire logic signed [31:0] s_trans_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_out_rot_00,
    output logic signed [31:0]      m_out_rot_01,
    output logic signed [31:0]      m_out_rot_02,
    output logic signed [31:0]      m_out_trans_x,
    output logic signed [31:0]      m_out_rot_10,
    output logic signed [31:0]      m_out_rot_11,
    output logic signed [31:0]      m_out_rot_12,
    output logic signed [31:0]      m_out_trans_y,
    output logic signed [31:0]      m_out_rot_20,
    output logic signed [31:0]      m_out_rot_21,
    output logic signed [31:0]      m_out_rot_22,
    output logic signed [31:0]      m_out_trans_z,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata
);

    dp_ctrl_t dp_ctrl;
    pose_t    in_pose;
    pose_t    out_pose;

    assign in_pose[0]  = s_rot_00;
    assign in_pose[1]  = s_rot_01;
    assign in_pose[2]  = s_rot_02;
    assign in_pose[3]  = s_trans_x;
    assign in_pose[4]  = s_rot_10;
    assign in_pose[5]  = s_rot_11;
    assign in_pose[6]  = s_rot_12;
    assign in_pose[7]  = s_trans_y;
    assign in_pose[8]  = s_rot_20;
    assign in_pose[9]  = s_rot_21;
    assign in_pose[10] = s_rot_22;
    assign in_pose[11] = s_trans_z;

    assign m_out_rot_00  = out_pose[0];
    assign m_out_rot_01  = out_pose[1];
    assign m_out_rot_02  = out_pose[2];
    assign m_out_trans_x = out_pose[3];
    assign m_out_rot_10  = out_pose[4];
    assign m_out_rot_11  = out_pose[5];
    assign m_out_rot_12  = out_pose[6];
    assign m_out_trans_y = out_pose[7];
    assign m_out_rot_20  = out_pose[8];
    assign m_out_rot_21  = out_pose[9];
    assign m_out_rot_22  = out_pose[10];
    assign m_out_trans_z = out_pose[11];

    rpcc_sequencer u_sequencer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (dp_ctrl)
    );

    rpcc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (dp_ctrl),
        .in_pose  (in_pose),
        .out_pose (out_pose)
    );

    `RPCC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `RPCC_ASSERT_IMP(a_commit_into_free_slot, aclk, aresetn, dp_ctrl.commit, !m_valid || m_ready)
    `RPCC_ASSERT_IMP(a_issue_only_when_busy, aclk, aresetn, dp_ctrl.issue, !s_ready && !dp_ctrl.commit)

endmodule

`default_nettype wire

>>> src/rpcc_sequencer.sv
// Microcode sequencer: step counter, program table, handshake and mode register.
`default_nettype none

module rpcc_sequencer
    import rpcc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    output dp_ctrl_t  ctrl
);

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            mode_reg;
    logic            out_valid_reg, out_valid_next;
    ucode_word_t     word;

    assign word = UCODE_ROM[pc_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                pc_next = '0;
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (word.done) begin
                    state_next = ST_FINISH;
                end else if (word.jump_world && mode_reg) begin
                    pc_next = word.target;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = out_valid_reg;
        ctrl.capture = s_valid && (state_reg == ST_IDLE);
        ctrl.issue   = (state_reg == ST_RUN) && word.mac;
        ctrl.word    = word;
        ctrl.commit  = (state_reg == ST_FINISH) && (!out_valid_reg || m_ready);
        ctrl.mode    = mode_reg;
    end

endmodule

`default_nettype wire

>>> src/rpcc_datapath.sv
// Pose banks, shared multiply-accumulate pipeline, rounding and saturation.
`default_nettype none

module rpcc_datapath
    import rpcc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dp_ctrl_t ctrl,
    input  wire pose_t    in_pose,
    output pose_t         out_pose
);

    typedef struct packed {
        logic             sub;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] dst;
    } mac_tag_t;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    pose_t cur_reg, prev_reg, res_reg, out_reg;

    logic signed [WORD_W-1:0] a_next, b_next, a_reg, b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext, acc_base, acc_next, acc_reg;
    logic signed [ACC_W-1:0]  rnd, shifted;
    logic [WORD_W-1:0]        sat_word;
    logic                     v0_reg, v1_reg, v2_reg;
    mac_tag_t                 tag_next, tag0_reg, tag1_reg, tag2_reg;

    always_comb begin
        unique case (ctrl.word.a_src)
            SRC_CUR:  a_next = cur_reg[ctrl.word.a_idx];
            SRC_PREV: a_next = prev_reg[ctrl.word.a_idx];
            SRC_RES:  a_next = res_reg[ctrl.word.a_idx];
            SRC_ONE:  a_next = Q30_ONE;
            default:  a_next = Q30_ONE;
        endcase
        unique case (ctrl.word.b_src)
            SRC_CUR:  b_next = cur_reg[ctrl.word.b_idx];
            SRC_PREV: b_next = prev_reg[ctrl.word.b_idx];
            SRC_RES:  b_next = res_reg[ctrl.word.b_idx];
            SRC_ONE:  b_next = Q30_ONE;
            default:  b_next = Q30_ONE;
        endcase
        tag_next.sub   = ctrl.word.sub;
        tag_next.first = ctrl.word.first;
        tag_next.last  = ctrl.word.last;
        tag_next.dst   = ctrl.word.dst;
    end

    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_base = tag1_reg.first ? '0 : acc_reg;
        acc_next = tag1_reg.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end

    // round half up at the Q30 point, then clamp to the word range
    always_comb begin
        rnd     = acc_reg + RND_HALF;
        shifted = rnd >>> FRAC_SHIFT;
        if (shifted > SAT_MAX) begin
            sat_word = SAT_MAX[WORD_W-1:0];
        end else if (shifted < SAT_MIN) begin
            sat_word = SAT_MIN[WORD_W-1:0];
        end else begin
            sat_word = shifted[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= ctrl.issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        tag0_reg <= tag_next;
        prod_reg <= a_reg * b_reg;
        tag1_reg <= tag0_reg;
        tag2_reg <= tag1_reg;
        if (v1_reg) begin
            acc_reg <= acc_next;
        end
        if (v2_reg && tag2_reg.last) begin
            res_reg[tag2_reg.dst] <= sat_word;
        end
        if (ctrl.capture) begin
            cur_reg <= in_pose;
        end
        if (ctrl.commit) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= POSE_IDENTITY;
        end else if (ctrl.commit) begin
            prev_reg <= ctrl.mode ? res_reg : cur_reg;
        end
    end

    assign out_pose = out_reg;

endmodule

`default_nettype wire

>>> sim/rpcc_pose_checker.sv
// Pose chain converter checker: predicts each converted pose and compares every result beat.
module rpcc_pose_checker
    import rpcc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  pose_t s_pose,
    input  logic  m_valid,
    input  logic  m_ready,
    input  pose_t m_pose,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    output int    fail_count,
    output int    poses_due
);

    localparam logic signed [71:0] ROUND_HALF = 72'sd536870912;
    localparam logic signed [71:0] SAT_HI     = 72'sd2147483647;
    localparam logic signed [71:0] SAT_LO     = -72'sd2147483648;

    typedef logic signed [33:0] term_t;
    typedef logic [5:0][33:0]   term_vec_t;

    logic  world_mode;
    pose_t prev_pose;
    pose_t want_pose;
    pose_t due_poses [$];

    initial begin
        fail_count = 0;
        poses_due  = 0;
        world_mode = 1'b0;
        prev_pose  = POSE_IDENTITY;
    end

    function automatic term_t widen(input logic [31:0] w);
        return {{2{w[31]}}, w};
    endfunction

    // Exact sum of products, then divide by 2^30 rounding half up, and saturate.
    function automatic logic [31:0] q30_dot(input term_vec_t a, input term_vec_t b, input int n);
        logic signed [71:0] acc;
        logic signed [71:0] ea;
        logic signed [71:0] eb;
        term_t xa;
        term_t xb;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            xa  = a[i];
            xb  = b[i];
            ea  = xa;
            eb  = xb;
            acc = acc + ea * eb;
        end
        acc = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        if (acc > SAT_HI) return SAT_HI[31:0];
        if (acc < SAT_LO) return SAT_LO[31:0];
        return acc[31:0];
    endfunction

    function automatic pose_t convert_pose(input pose_t cur, input pose_t prev, input logic world);
        pose_t     res;
        term_vec_t a;
        term_vec_t b;
        res = '0;
        a   = '0;
        b   = '0;
        if (!world) begin
            // inv(cur) * prev
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int k = 0; k < 3; k++) begin
                        a[k] = widen(cur[k * 4 + r]);
                        b[k] = widen(prev[k * 4 + c]);
                    end
                    res[r * 4 + c] = q30_dot(a, b, 3);
                end
                for (int k = 0; k < 3; k++) begin
                    a[k]     = widen(cur[k * 4 + r]);
                    b[k]     = widen(prev[k * 4 + 3]);
                    a[k + 3] = widen(cur[k * 4 + r]);
                    b[k + 3] = -widen(cur[k * 4 + 3]);
                end
                res[r * 4 + 3] = q30_dot(a, b, 6);
            end
        end else begin
            // prev * inv(cur); translation uses the rounded rotation
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int k = 0; k < 3; k++) begin
                        a[k] = widen(prev[r * 4 + k]);
                        b[k] = widen(cur[c * 4 + k]);
                    end
                    res[r * 4 + c] = q30_dot(a, b, 3);
                end
            end
            for (int r = 0; r < 3; r++) begin
                a[0] = widen(prev[r * 4 + 3]);
                b[0] = widen(Q30_ONE);
                for (int k = 0; k < 3; k++) begin
                    a[k + 1] = -widen(res[r * 4 + k]);
                    b[k + 1] = widen(cur[k * 4 + 3]);
                end
                res[r * 4 + 3] = q30_dot(a, b, 4);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("rpcc check: %s", msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            world_mode = 1'b0;
            prev_pose  = POSE_IDENTITY;
            due_poses.delete();
        end else begin
            // retire the result beat before queueing a new pose
            if (m_valid && m_ready) begin
                if (due_poses.size() == 0) begin
                    report_mismatch("result beat with no pose due");
                end else begin
                    want_pose = due_poses.pop_front();
                    for (int k = 0; k < POSE_WORDS; k++) begin
                        if (m_pose[k] !== want_pose[k]) begin
                            report_mismatch($sformatf("row %0d col %0d got %h want %h",
                                                      k / 4, k % 4, m_pose[k], want_pose[k]));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want_pose = convert_pose(s_pose, prev_pose, world_mode);
                due_poses = {due_poses, want_pose};
                prev_pose = world_mode ? want_pose : s_pose;
            end
            if (cfg_we) world_mode = cfg_wdata;
        end
        poses_due = due_poses.size();
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for the pose chain converter: clock, reset, pose stimulus and verdict.
module tb_top;
    import rpcc_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 64;

    typedef enum logic [1:0] {
        RDY_FREE,
        RDY_COIN,
        RDY_SPARSE,
        RDY_BLOCK
    } ready_style_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    wire   s_ready;
    pose_t s_pose;
    wire   m_valid;
    logic  m_ready = 1'b0;
    wire [POSE_WORDS-1:0][WORD_W-1:0] m_pose;
    logic  cfg_we;
    logic  cfg_wdata;

    int fail_count;
    int poses_due;
    int burst_left;
    int cycle_count;
    int sent;
    int phase_len;
    logic mode_bit;

    ready_style_t ready_style = RDY_FREE;
    int           ready_left  = 0;

    rigid_pose_chain_converter_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rot_00      (s_pose[0]),
        .s_rot_01      (s_pose[1]),
        .s_rot_02      (s_pose[2]),
        .s_trans_x     (s_pose[3]),
        .s_rot_10      (s_pose[4]),
        .s_rot_11      (s_pose[5]),
        .s_rot_12      (s_pose[6]),
        .s_trans_y     (s_pose[7]),
        .s_rot_20      (s_pose[8]),
        .s_rot_21      (s_pose[9]),
        .s_rot_22      (s_pose[10]),
        .s_trans_z     (s_pose[11]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_rot_00  (m_pose[0]),
        .m_out_rot_01  (m_pose[1]),
        .m_out_rot_02  (m_pose[2]),
        .m_out_trans_x (m_pose[3]),
        .m_out_rot_10  (m_pose[4]),
        .m_out_rot_11  (m_pose[5]),
        .m_out_rot_12  (m_pose[6]),
        .m_out_trans_y (m_pose[7]),
        .m_out_rot_20  (m_pose[8]),
        .m_out_rot_21  (m_pose[9]),
        .m_out_rot_22  (m_pose[10]),
        .m_out_trans_z (m_pose[11]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    rpcc_pose_checker pose_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pose     (s_pose),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pose     (m_pose),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .poses_due  (poses_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: switch between free flow, coin flips, sparse accepts and hard stalls.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            ready_left  = (ready_style == RDY_BLOCK) ? $urandom_range(1, 80)
                                                     : $urandom_range(20, 400);
        end
        ready_left--;
        case (ready_style)
            RDY_FREE:   m_ready = 1'b1;
            RDY_COIN:   m_ready = 1'($urandom_range(0, 1));
            RDY_SPARSE: m_ready = ($urandom_range(0, 3) == 0);
            default:    m_ready = (ready_left == 0);
        endcase
    end

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            4:       return 32'hFFFF_FFFF;
            5:       return Q30_ONE;
            6:       return 32'hC000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_t flat_pose(input logic [31:0] rot_w, input logic [31:0] trans_w);
        pose_t p;
        for (int k = 0; k < POSE_WORDS; k++) p[k] = (k % 4 == 3) ? trans_w : rot_w;
        return p;
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        for (int k = 0; k < POSE_WORDS; k++) p[k] = $urandom;
        return p;
    endfunction

    function automatic pose_t edge_pose();
        pose_t p;
        for (int k = 0; k < POSE_WORDS; k++) p[k] = edge_word();
        return p;
    endfunction

    // Signed permutation rotation with small noise and a translation of random scale.
    function automatic pose_t rigid_pose();
        pose_t              p;
        int                 amp;
        int                 pc [3];
        int                 unit;
        logic signed [31:0] tw;
        case ($urandom_range(0, 3))
            0:       amp = 0;
            1:       amp = 255;
            2:       amp = 65535;
            default: amp = 4194303;
        endcase
        pc[0] = $urandom_range(0, 2);
        pc[1] = (pc[0] + 1 + $urandom_range(0, 1)) % 3;
        pc[2] = 3 - pc[0] - pc[1];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                unit = 0;
                if (c == pc[r]) unit = $urandom_range(0, 1) ? -1073741824 : 1073741824;
                p[r * 4 + c] = 32'(unit + int'($urandom_range(0, 2 * amp)) - amp);
            end
            tw = $urandom;
            p[r * 4 + 3] = tw >>> $urandom_range(0, 27);
        end
        return p;
    endfunction

    function automatic pose_t pick_pose();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return rigid_pose();
        if (roll < 82) return random_pose();
        if (roll < 94) return edge_pose();
        return POSE_IDENTITY;
    endfunction

    task automatic send_pose(input pose_t p);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(13, 60);
                default: gap = $urandom_range(1, 12);
            endcase
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_pose  = p;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic write_mode(input logic world);
        s_valid = 1'b0;
        while (poses_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = world;
        @(negedge aclk);
        cfg_we     = 1'b0;
        burst_left = 0;
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_pose     = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        burst_left = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // local mode straight from reset, then world mode on the pose left behind
        for (int m = 0; m < 2; m++) begin
            if (m == 1) write_mode(1'b1);
            send_pose(rigid_pose());
            send_pose(POSE_IDENTITY);
            send_pose(flat_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF));
            send_pose(flat_pose(32'h8000_0000, 32'h8000_0000));
            send_pose(flat_pose(32'h0000_0000, 32'h0000_0000));
            send_pose(flat_pose(32'h7FFF_FFFF, 32'h8000_0000));
            send_pose(flat_pose(32'h8000_0000, 32'h7FFF_FFFF));
            send_pose(random_pose());
            send_pose(edge_pose());
            send_pose(rigid_pose());
        end

        mode_bit = 1'b1;
        sent     = 0;
        while (sent < RANDOM_ITEMS) begin
            mode_bit = ~mode_bit;
            write_mode(mode_bit);
            phase_len = $urandom_range(120, 300);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                send_pose(pick_pose());
                sent++;
            end
        end

        s_valid = 1'b0;
        while (poses_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
